@@ src/fmpi_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and register map of the falling mass plant integrator
package fmpi_pkg;

  localparam int WORD_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int FORCE_W    = 32;
  localparam int STEP_W     = 17;
  localparam int PCT_W      = 23;
  localparam int POS_W      = 31;
  localparam int VEL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int UREG_W     = 31;

  localparam logic [UREG_W-1:0]        RST_FORCE_LIMIT = 31'd655360;
  localparam logic signed [FORCE_W-1:0] RST_GRAVITY    = 32'sd642908;
  localparam logic [UREG_W-1:0]        RST_DRAG        = 31'd0;
  localparam logic [UREG_W-1:0]        RST_INV_MASS    = 31'd65536;
  localparam logic [UREG_W-1:0]        RST_POS_LIMIT   = 31'd655360;
  localparam logic [UREG_W-1:0]        RST_PCT_SCALE   = 31'd655360;
  localparam logic                     RST_USE_TRAP    = 1'b0;
  localparam logic                     RST_DRAG_EN     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_LIMIT,
    REG_GRAVITY,
    REG_DRAG,
    REG_INV_MASS,
    REG_POS_LIMIT,
    REG_PCT_SCALE,
    REG_USE_TRAP,
    REG_DRAG_EN
  } cfg_reg_e;

  typedef struct packed {
    logic [UREG_W-1:0]         force_limit;
    logic signed [FORCE_W-1:0] slope_load;
    logic [UREG_W-1:0]         drag_coefficient;
    logic [UREG_W-1:0]         inverse_mass;
    logic [UREG_W-1:0]         position_limit;
    logic [UREG_W-1:0]         percent_scale;
    logic                      use_trapezoid;
    logic                      drag_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_VV,
    S_F_VV,
    S_M_DRAG,
    S_F_NET,
    S_M_INV,
    S_F_INV,
    S_M_DT1,
    S_F_VEL,
    S_M_DT2,
    S_F_POS,
    S_M_PCT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_VV,
    MUL_DRAG,
    MUL_INV,
    MUL_DT1,
    MUL_DT2,
    MUL_PCT
  } mul_sel_e;

  typedef enum logic [2:0] {
    FOLD_NONE,
    FOLD_M,
    FOLD_NET,
    FOLD_VEL,
    FOLD_POS
  } fold_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    fold_e    fold;
    logic     commit;
  } cmd_t;

endpackage

@@ src/fmpi_cfg.sv @@
`timescale 1ns / 1ps
// configuration register file of the plant integrator
module fmpi_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fmpi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fmpi_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output fmpi_pkg::cfg_t                     cfg_o
);
  import fmpi_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FORCE_LIMIT: cfg_d.force_limit      = cfg_data_i[UREG_W-1:0];
        REG_GRAVITY:     cfg_d.slope_load       = cfg_data_i[FORCE_W-1:0];
        REG_DRAG:        cfg_d.drag_coefficient = cfg_data_i[UREG_W-1:0];
        REG_INV_MASS:    cfg_d.inverse_mass     = cfg_data_i[UREG_W-1:0];
        REG_POS_LIMIT:   cfg_d.position_limit   = cfg_data_i[UREG_W-1:0];
        REG_PCT_SCALE:   cfg_d.percent_scale    = cfg_data_i[UREG_W-1:0];
        REG_USE_TRAP:    cfg_d.use_trapezoid    = cfg_data_i[0];
        REG_DRAG_EN:     cfg_d.drag_enable      = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_limit      <= RST_FORCE_LIMIT;
      cfg_q.slope_load       <= RST_GRAVITY;
      cfg_q.drag_coefficient <= RST_DRAG;
      cfg_q.inverse_mass     <= RST_INV_MASS;
      cfg_q.position_limit   <= RST_POS_LIMIT;
      cfg_q.percent_scale    <= RST_PCT_SCALE;
      cfg_q.use_trapezoid    <= RST_USE_TRAP;
      cfg_q.drag_enable      <= RST_DRAG_EN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/fmpi_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer that walks one item through the shared multiplier and owns the handshakes
module fmpi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fmpi_pkg::cmd_t cmd_o
);
  import fmpi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !(out_valid_q && out_stall_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '{load: 1'b0, mul_en: 1'b0, mul_sel: MUL_VV, fold: FOLD_NONE,
                    commit: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_M_VV;
        end
      end
      S_M_VV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_VV;
        state_d       = S_F_VV;
      end
      S_F_VV: begin
        cmd_o.fold = FOLD_M;
        state_d    = S_M_DRAG;
      end
      S_M_DRAG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DRAG;
        state_d       = S_F_NET;
      end
      S_F_NET: begin
        cmd_o.fold = FOLD_NET;
        state_d    = S_M_INV;
      end
      S_M_INV: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INV;
        state_d       = S_F_INV;
      end
      S_F_INV: begin
        cmd_o.fold = FOLD_M;
        state_d    = S_M_DT1;
      end
      S_M_DT1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DT1;
        state_d       = S_F_VEL;
      end
      S_F_VEL: begin
        cmd_o.fold = FOLD_VEL;
        state_d    = S_M_DT2;
      end
      S_M_DT2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DT2;
        state_d       = S_F_POS;
      end
      S_F_POS: begin
        cmd_o.fold = FOLD_POS;
        state_d    = S_M_PCT;
      end
      S_M_PCT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PCT;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // hold here until the output register is free to take the result
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/fmpi_dp.sv @@
`timescale 1ns / 1ps
// datapath: shared fixed point multiplier, saturating adders and plant state
module fmpi_dp #(
  parameter int FRAC_BITS = fmpi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fmpi_pkg::cmd_t                     cmd_i,
  input  fmpi_pkg::cfg_t                     cfg_i,
  input  logic signed [fmpi_pkg::FORCE_W-1:0] force_command_i,
  input  logic [fmpi_pkg::STEP_W-1:0]        step_time_i,
  output logic [fmpi_pkg::PCT_W-1:0]         position_percent_o,
  output logic [fmpi_pkg::POS_W-1:0]         position_now_o,
  output logic signed [fmpi_pkg::VEL_W-1:0]  velocity_now_o
);
  import fmpi_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int RW = PW - FRAC_BITS;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]        PCT_MAX = {{(W-PCT_W){1'b0}}, {PCT_W{1'b1}}};

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] x);
    if (x > $signed({{2{WMAX[W-1]}}, WMAX})) begin
      sat = WMAX;
    end else if (x < $signed({{2{WMIN[W-1]}}, WMIN})) begin
      sat = WMIN;
    end else begin
      sat = x[W-1:0];
    end
  endfunction

  // floor of the mean of two words
  function automatic logic signed [W-1:0] half(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s    = {a[W-1], a} + {b[W-1], b};
    half = s[W:1];
  endfunction

  function automatic logic signed [W+1:0] ext(input logic signed [W-1:0] x);
    ext = {{2{x[W-1]}}, x};
  endfunction

  // plant state
  logic signed [W-1:0] vel_q, posr_q, last_q;
  // per-item working registers
  logic signed [W-1:0] f_q, m_q, net_q, drive_q, vnew_q, vdrive_q, pos_q;
  logic [STEP_W-1:0]   dt_q;
  logic [PW-1:0]       prod_q, prod_d;
  logic                neg_q, neg_d;
  // result register
  logic [PCT_W-1:0]    pct_out_q;
  logic [POS_W-1:0]    pos_out_q;
  logic signed [W-1:0] vel_out_q;

  // input force clamp
  logic signed [W:0] f_in, f_lim, f_nlim, f_clamped;
  always_comb begin
    f_in   = {force_command_i[FORCE_W-1], force_command_i};
    f_lim  = $signed({{(W+1-UREG_W){1'b0}}, cfg_i.force_limit});
    f_nlim = -f_lim;
    if (f_in > f_lim) begin
      f_clamped = f_lim;
    end else if (f_in < f_nlim) begin
      f_clamped = f_nlim;
    end else begin
      f_clamped = f_in;
    end
  end

  // multiplier operand select, magnitudes with the sign carried apart
  logic [W-1:0] amag, bmag;
  always_comb begin
    amag  = '0;
    bmag  = '0;
    neg_d = 1'b0;
    case (cmd_i.mul_sel)
      MUL_VV: begin
        amag = mag(vel_q);
        bmag = mag(vel_q);
      end
      MUL_DRAG: begin
        amag  = mag(m_q);
        bmag  = {{(W-UREG_W){1'b0}}, cfg_i.drag_coefficient};
        neg_d = m_q[W-1];
      end
      MUL_INV: begin
        amag  = mag(drive_q);
        bmag  = {{(W-UREG_W){1'b0}}, cfg_i.inverse_mass};
        neg_d = drive_q[W-1];
      end
      MUL_DT1: begin
        amag  = mag(m_q);
        bmag  = {{(W-STEP_W){1'b0}}, dt_q};
        neg_d = m_q[W-1];
      end
      MUL_DT2: begin
        amag  = mag(vdrive_q);
        bmag  = {{(W-STEP_W){1'b0}}, dt_q};
        neg_d = vdrive_q[W-1];
      end
      MUL_PCT: begin
        amag  = mag(pos_q);
        bmag  = {{(W-UREG_W){1'b0}}, cfg_i.percent_scale};
        neg_d = pos_q[W-1];
      end
      default: begin
        amag  = '0;
        bmag  = '0;
        neg_d = 1'b0;
      end
    endcase
    prod_d = PW'(amag) * PW'(bmag);
  end

  // scale the registered product back, saturate, reapply the sign
  logic [RW-1:0]       prod_sh;
  logic [W-1:0]        mlim, mclip;
  logic signed [W-1:0] mres;
  always_comb begin
    prod_sh = prod_q[PW-1:FRAC_BITS];
    mlim    = WMAX + {{(W-1){1'b0}}, neg_q};
    mclip   = (prod_sh > RW'(mlim)) ? mlim : prod_sh[W-1:0];
    mres    = neg_q ? -$signed(mclip) : $signed(mclip);
  end

  // fold results
  logic signed [W-1:0] drag_term, net_c, vnew_c, pos_sum, pos_c, plim;
  logic [W-1:0]        pct_c;
  always_comb begin
    drag_term = cfg_i.drag_enable ? mres : '0;
    net_c     = sat(ext(f_q) - ext(cfg_i.slope_load) - ext(drag_term));
    vnew_c    = sat(ext(vel_q) + ext(mres));
    pos_sum   = sat(ext(posr_q) + ext(mres));
    plim      = $signed({{(W-UREG_W){1'b0}}, cfg_i.position_limit});
    if (pos_sum > plim) begin
      pos_c = plim;
    end else if (pos_sum < 0) begin
      pos_c = '0;
    end else begin
      pos_c = pos_sum;
    end
    if (mres < 0) begin
      pct_c = '0;
    end else if ($unsigned(mres) > PCT_MAX) begin
      pct_c = PCT_MAX;
    end else begin
      pct_c = $unsigned(mres);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q  <= f_clamped[W-1:0];
      dt_q <= step_time_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
    end
    case (cmd_i.fold)
      FOLD_M: m_q <= mres;
      FOLD_NET: begin
        net_q   <= net_c;
        drive_q <= cfg_i.use_trapezoid ? half(last_q, net_c) : net_c;
      end
      FOLD_VEL: begin
        vnew_q   <= vnew_c;
        vdrive_q <= cfg_i.use_trapezoid ? half(vel_q, vnew_c) : vnew_c;
      end
      FOLD_POS: pos_q <= pos_c;
      default: ;
    endcase
    if (cmd_i.commit) begin
      pct_out_q <= pct_c[PCT_W-1:0];
      pos_out_q <= pos_q[POS_W-1:0];
      vel_out_q <= vnew_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q  <= '0;
      posr_q <= '0;
      last_q <= '0;
    end else if (cmd_i.commit) begin
      vel_q  <= vnew_q;
      posr_q <= pos_q;
      if (cfg_i.use_trapezoid) begin
        last_q <= net_q;
      end
    end
  end

  assign position_percent_o = pct_out_q;
  assign position_now_o     = pos_out_q;
  assign velocity_now_o     = vel_out_q[VEL_W-1:0];

endmodule

@@ src/falling_mass_plant_integrator_unit.sv @@
`timescale 1ns / 1ps
// the result register loads in S_DONE once the output register is free
// items are taken one at a time, as six dependent products share the single
// multiplier, each a multiply step, all but the last followed by a fold step
// a finished result waits in the output register while the next item is taken
// reset clears velocity, position and last net force to zero, config to defaults
module falling_mass_plant_integrator_unit #(
  parameter int FRAC_BITS = fmpi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fmpi_pkg::FORCE_W-1:0] force_command_i,
  input  logic [fmpi_pkg::STEP_W-1:0]         step_time_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fmpi_pkg::PCT_W-1:0]          position_percent_o,
  output logic [fmpi_pkg::POS_W-1:0]          position_now_o,
  output logic signed [fmpi_pkg::VEL_W-1:0]   velocity_now_o,
  input  logic                                cfg_we_i,
  input  logic [fmpi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fmpi_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fmpi_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  fmpi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fmpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fmpi_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .force_command_i    (force_command_i),
    .step_time_i        (step_time_i),
    .position_percent_o (position_percent_o),
    .position_now_o     (position_now_o),
    .velocity_now_o     (velocity_now_o)
  );

endmodule

@@ dv/plant_check_pkg.sv @@
`timescale 1ns / 1ps
// expected-result tracking for the falling mass plant integrator: fixed-point plant predictor
package plant_check_pkg;
  import fmpi_pkg::*;

  localparam longint WORD_MAX = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam longint PCT_MAX  = (longint'(1) <<< PCT_W) - 1;
  localparam int     FRAC     = FRAC_BITS_DEF;

  typedef struct {
    logic [PCT_W-1:0]        percent;
    logic [POS_W-1:0]        position;
    logic signed [VEL_W-1:0] velocity;
  } plant_sample_t;

  class plant_scoreboard;
    // register copies
    longint force_cap, gravity, drag, inv_mass, pos_cap, pct_scale;
    bit     trapezoid, drag_on;
    // plant state
    longint velocity, position, prev_net;
    plant_sample_t expected_q[$];
    int unsigned errors;

    function new();
      force_cap = RST_FORCE_LIMIT;
      gravity   = RST_GRAVITY;
      drag      = RST_DRAG;
      inv_mass  = RST_INV_MASS;
      pos_cap   = RST_POS_LIMIT;
      pct_scale = RST_PCT_SCALE;
      trapezoid = RST_USE_TRAP;
      drag_on   = RST_DRAG_EN;
      velocity  = 0;
      position  = 0;
      prev_net  = 0;
      errors    = 0;
    endfunction

    static function longint clip_word(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
    endfunction

    // magnitude product truncated toward zero, sign put back, saturated
    static function longint fix_mul(longint a, longint b);
      longint unsigned ma, mb, prod, lim;
      bit neg;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      lim = WORD_MAX + (neg ? 1 : 0);
      prod = (ma * mb) >> FRAC;
      if (prod > lim) prod = lim;
      return neg ? -longint'(prod) : longint'(prod);
    endfunction

    // average rounding toward minus infinity
    static function longint halve(longint a, longint b);
      longint s;
      s = a + b;
      return s >>> 1;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FORCE_LIMIT: force_cap = data[UREG_W-1:0];
        REG_GRAVITY:     gravity = $signed(data);
        REG_DRAG:        drag = data[UREG_W-1:0];
        REG_INV_MASS:    inv_mass = data[UREG_W-1:0];
        REG_POS_LIMIT:   pos_cap = data[UREG_W-1:0];
        REG_PCT_SCALE:   pct_scale = data[UREG_W-1:0];
        REG_USE_TRAP:    trapezoid = data[0];
        REG_DRAG_EN:     drag_on = data[0];
        default: ;
      endcase
    endfunction

    // one plant step per accepted input transfer
    function void note_transfer(input logic signed [FORCE_W-1:0] force_cmd,
                                input logic [STEP_W-1:0] dt_bits);
      longint f, dt, sum_f, drive, vnew, vdrive, pos, pct;
      plant_sample_t smp;
      f  = force_cmd;
      dt = dt_bits;
      if (f > force_cap) f = force_cap;
      if (f < -force_cap) f = -force_cap;
      sum_f = f - gravity;
      if (drag_on) sum_f = sum_f - fix_mul(drag, fix_mul(velocity, velocity));
      sum_f = clip_word(sum_f);
      drive  = trapezoid ? halve(prev_net, sum_f) : sum_f;
      vnew   = clip_word(velocity + fix_mul(fix_mul(drive, inv_mass), dt));
      vdrive = trapezoid ? halve(velocity, vnew) : vnew;
      pos    = clip_word(position + fix_mul(vdrive, dt));
      if (pos > pos_cap) pos = pos_cap;
      if (pos < 0) pos = 0;
      pct = fix_mul(pos, pct_scale);
      if (pct > PCT_MAX) pct = PCT_MAX;
      if (pct < 0) pct = 0;
      if (trapezoid) prev_net = sum_f;
      velocity = vnew;
      position = pos;
      smp.percent  = pct[PCT_W-1:0];
      smp.position = pos[POS_W-1:0];
      smp.velocity = vnew[VEL_W-1:0];
      expected_q.push_back(smp);
    endfunction

    function void check_transfer(logic [PCT_W-1:0] pct, logic [POS_W-1:0] pos,
                                 logic signed [VEL_W-1:0] vel);
      plant_sample_t smp;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: pct %0d pos %0d vel %0d",
               pct, pos, vel);
        errors++;
        return;
      end
      smp = expected_q.pop_front();
      if (pct !== smp.percent) begin
        $error("position_percent: expected %0d, actual %0d", smp.percent, pct);
        errors++;
      end
      if (pos !== smp.position) begin
        $error("position_now: expected %0d, actual %0d", smp.position, pos);
        errors++;
      end
      if (vel !== smp.velocity) begin
        $error("velocity_now: expected %0d, actual %0d", smp.velocity, vel);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top: drives the plant integrator with directed and random steps and checks results
module tb_top;
  import fmpi_pkg::*;
  import plant_check_pkg::*;

  localparam int     CLK_PERIOD     = 12;
  localparam longint RUN_LIMIT      = 600000;
  localparam int     RANDOM_PHASES  = 12;
  localparam int     ITEMS_PER_PHASE = 120;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [FORCE_W-1:0]  force_command_i;
  logic [STEP_W-1:0]          step_time_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [PCT_W-1:0]           position_percent_o;
  logic [POS_W-1:0]           position_now_o;
  logic signed [VEL_W-1:0]    velocity_now_o;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  plant_scoreboard plant;

  falling_mass_plant_integrator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .force_command_i    (force_command_i),
    .step_time_i        (step_time_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .position_percent_o (position_percent_o),
    .position_now_o     (position_now_o),
    .velocity_now_o     (velocity_now_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // result side: sample pre-edge values, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      plant.check_transfer(position_percent_o, position_now_o, velocity_now_o);
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(input logic signed [FORCE_W-1:0] f, input logic [STEP_W-1:0] dt);
    while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    force_command_i <= f;
    step_time_i     <= dt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    plant.note_transfer(f, dt);
  endtask

  // registers change only with the pipeline drained
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (plant.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    plant.set_register(idx, data);
  endtask

  task automatic apply_settings(input logic [31:0] fl, input logic [31:0] grav,
                                input logic [31:0] drg, input logic [31:0] inv,
                                input logic [31:0] plim, input logic [31:0] pscale,
                                input logic trap, input logic den);
    settle_idle();
    write_reg(REG_FORCE_LIMIT, fl);
    write_reg(REG_GRAVITY, grav);
    write_reg(REG_DRAG, drg);
    write_reg(REG_INV_MASS, inv);
    write_reg(REG_POS_LIMIT, plim);
    write_reg(REG_PCT_SCALE, pscale);
    write_reg(REG_USE_TRAP, {31'd0, trap});
    write_reg(REG_DRAG_EN, {31'd0, den});
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_settings();
    logic [31:0] fl, grav, drg, inv, plim, pscale;
    logic        trap, den;
    longint      scale;
    fl   = $urandom_range(0, 32'h00FF_FFFF);
    grav = $urandom_range(0, 32'h01FF_FFFF) - 32'h00FF_FFFF;
    drg  = $urandom_range(0, 32'h0000_3FFF);
    inv  = $urandom_range(32'h0000_1000, 32'h0004_0000);
    plim = $urandom_range(32'h0001_0000, 32'h0400_0000);
    trap = 1'($urandom_range(1));
    den  = 1'($urandom_range(1));
    // occasional extreme or raw register word
    case ($urandom_range(9))
      0: fl = 32'h7FFF_FFFF;
      1: grav = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: drg = $urandom;
      3: inv = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
      4: plim = 32'h7FFF_FFFF;
      5: plim = 32'h1;
      6: fl = 32'h0;
      default: ;
    endcase
    scale  = (longint'(100) <<< 32) / longint'(plim[30:0]);
    pscale = (scale > WORD_MAX) ? 32'h7FFF_FFFF : scale[31:0];
    if ($urandom_range(7) == 0) pscale = $urandom;
    apply_settings(fl, grav, drg, inv, plim, pscale, trap, den);
  endtask

  task automatic pick_item(output logic signed [FORCE_W-1:0] f, output logic [STEP_W-1:0] dt);
    int unsigned r;
    longint      lvl;
    r = $urandom_range(99);
    if (r < 15) begin
      f = $urandom;
    end else if (r < 40) begin
      f = $urandom_range(0, 262143) - 131072;
    end else begin
      // commands around the force limit on either side
      lvl = plant.force_cap + longint'($urandom_range(0, 4096)) - 2048;
      if (lvl > WORD_MAX) lvl = WORD_MAX;
      if ($urandom_range(1)) lvl = -lvl;
      f = lvl[31:0];
    end
    r = $urandom_range(99);
    if (r < 70) dt = STEP_W'($urandom_range(0, 4096));
    else if (r < 90) dt = STEP_W'($urandom_range(0, 65536));
    else dt = STEP_W'($urandom_range(0, 131071));
  endtask

  initial begin
    logic signed [FORCE_W-1:0] f;
    logic [STEP_W-1:0]         dt;
    plant = new();
    send_idle_pct = 14;
    recv_idle_pct = 54;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    force_command_i <= '0;
    step_time_i     <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_FORCE_LIMIT;
    cfg_data_i      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: euler, drag enabled with zero coefficient
    send_item(32'sh0000_0000, 17'd0);
    send_item(32'sh7FFF_FFFF, 17'd1);
    send_item(32'sh8000_0000, 17'd65536);
    send_item(-32'sd1, 17'd65536);
    send_item(32'sd655360, 17'd65536);
    send_item(32'sd655361, 17'd32768);
    send_item(-32'sd655360, 17'd131071);
    send_item(32'sh0000_0000, 17'd131071);
    send_item(32'sh1234_5678, 17'd1);

    // trapezoid, no drag, everything wide open: velocity, position and percent saturate
    apply_settings(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 1'b1, 1'b0);
    repeat (3) send_item(32'sh7FFF_FFFF, 17'd131071);
    repeat (2) send_item(32'sh8000_0000, 17'd131071);
    send_item(32'sh0000_0000, 17'd0);
    send_item(32'sd1, 17'd1);

    // zero position limit, zero force limit, most negative gravity, heavy drag
    apply_settings(32'h0, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0,
                   32'h000A_0000, 1'b0, 1'b1);
    send_item(32'sh7FFF_FFFF, 17'd65536);
    send_item(32'sh0000_0000, 17'd1);
    send_item(-32'sd1, 17'd131071);
    send_item(32'sh8000_0000, 17'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < RANDOM_PHASES / 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 54;
      end else if (ph < 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      repeat (ITEMS_PER_PHASE) begin
        pick_item(f, dt);
        send_item(f, dt);
      end
    end

    in_valid_i <= 1'b0;
    while (plant.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (plant.errors == 0)
      $display("** falling_mass_plant_integrator_unit: PASSED **");
    else
      $display("** falling_mass_plant_integrator_unit: FAILED **");
    $finish;
  end

  initial begin
    #(RUN_LIMIT * CLK_PERIOD);
    $display("** falling_mass_plant_integrator_unit: FAILED **");
    $finish;
  end

endmodule
